[src/assert_macros.svh]
// Assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/slpq_pkg.sv]
package slpq_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam int KEY_W = 17;

   typedef struct packed {
      logic             ins;
      logic             pop;
      logic             rem;
      logic             clr;
      logic [KEY_W-1:0] key;
   } ctrl_type;

endpackage

[src/slpq_cell.sv]
module slpq_cell #(
   parameter int HW = 8,
   parameter int CW = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  slpq_pkg::ctrl_type        ctrl,
   input  logic [HW-1:0]             new_handle,
   input  logic [CW-1:0]             target,
   input  logic                      left_valid,
   input  logic [slpq_pkg::KEY_W-1:0] left_key,
   input  logic [HW-1:0]             left_handle,
   input  logic                      left_ge,
   input  logic                      left_hit,
   input  logic                      right_valid,
   input  logic [slpq_pkg::KEY_W-1:0] right_key,
   input  logic [HW-1:0]             right_handle,
   output logic                      valid,
   output logic [slpq_pkg::KEY_W-1:0] key,
   output logic [HW-1:0]             handle,
   output logic                      ge,
   output logic                      hit
);
   import slpq_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [HW-1:0]    handle_ff, handle_in;

   // the new node lands in the first cell whose key is not below it
   assign ge  = !valid_ff || (ctrl.key <= key_ff);
   assign hit = left_hit || (valid_ff && (CW'(handle_ff) == target));

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctrl.clr) begin
         valid_in = 1'b0;
      end else if (ctrl.ins) begin
         if (ge && !left_ge) begin
            valid_in  = 1'b1;
            key_in    = ctrl.key;
            handle_in = new_handle;
         end else if (left_ge) begin
            valid_in  = left_valid;
            key_in    = left_key;
            handle_in = left_handle;
         end
      end else if (ctrl.pop || (ctrl.rem && hit)) begin
         valid_in  = right_valid;
         key_in    = right_key;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign valid  = valid_ff;
   assign key    = key_ff;
   assign handle = handle_ff;

endmodule

[src/sorted_list_priority_queue_unit.sv]
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_cmd .. req_target_handle
// rsp     | out       | rsp_valid, rsp_stall, rsp_status .. rsp_is_empty
// For every word, IDLE registers the command and reads the free-slot stack; then in EXEC
// the cell chain shifts and the slot memory is read or written.
// The next word is taken once the result has left or is leaving the output register.
// Reset empties the chain at once; slot memories need no clearing.
// A stalled result holds; no word is taken meanwhile.
module sorted_list_priority_queue_unit #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_position,
   input  logic [15:0] req_cost_so_far,
   input  logic [15:0] req_cost_estimate,
   input  logic [7:0]  req_target_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_node_handle,
   output logic [15:0] rsp_node_position,
   output logic [15:0] rsp_node_cost_so_far,
   output logic [15:0] rsp_node_cost_estimate,
   output logic [16:0] rsp_node_total,
   output logic [7:0]  rsp_head_handle,
   output logic        rsp_is_empty
);
   import slpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (AW > 8) ? AW : 8;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic st_ff;
   logic rsp_valid_ff;
   logic [1:0]  cmd_ff;
   logic [15:0] pos_ff, g_ff, h_ff;
   logic [CW-1:0] tgt_ff;
   logic [AW:0] sp_ff, used_ff;
   logic [AW-1:0] stack_rd_ff;
   logic [AW-1:0] stack_mem [CAPACITY];
   logic [15:0] mem_pos [CAPACITY];
   logic [15:0] mem_g [CAPACITY];
   logic [15:0] mem_h [CAPACITY];
   logic [15:0] dpos_ff, dg_ff, dh_ff;
   logic [1:0]  status_ff;
   logic [CW-1:0] hnd_ff;
   logic show_ff;

   logic accept, exec, full, found, do_push;
   logic [AW-1:0] new_handle, rd_addr, push_handle;
   ctrl_type ctrl;

   logic             c_valid [CAPACITY];
   logic [KEY_W-1:0] c_key [CAPACITY];
   logic [AW-1:0]    c_handle [CAPACITY];
   logic             c_ge [CAPACITY];
   logic             c_hit [CAPACITY];

   assign req_stall = (st_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign exec      = (st_ff == ST_EXEC);
   assign full      = (sp_ff == '0) && (used_ff == (AW+1)'(CAPACITY));
   assign found     = c_hit[CAPACITY-1];
   assign new_handle = (sp_ff != '0) ? stack_rd_ff : used_ff[AW-1:0];
   assign rd_addr   = (cmd_ff == CMD_POP) ? c_handle[0] : tgt_ff[AW-1:0];
   assign push_handle = rd_addr;
   assign do_push   = exec && (((cmd_ff == CMD_POP) && c_valid[0]) ||
                               ((cmd_ff == CMD_REMOVE) && found));

   always_comb begin
      ctrl.ins = exec && (cmd_ff == CMD_INSERT) && !full;
      ctrl.pop = exec && (cmd_ff == CMD_POP);
      ctrl.rem = exec && (cmd_ff == CMD_REMOVE);
      ctrl.clr = exec && (cmd_ff == CMD_CLEAR);
      ctrl.key = KEY_W'(g_ff) + KEY_W'(h_ff);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic             lv, lge, lhit, rv;
      logic [KEY_W-1:0] lk, rk;
      logic [AW-1:0]    lh, rh;
      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign lk = '0;
         assign lh = '0;
         assign lge = 1'b0;
         assign lhit = 1'b0;
      end else begin : g_mid
         assign lv = c_valid[i-1];
         assign lk = c_key[i-1];
         assign lh = c_handle[i-1];
         assign lge = c_ge[i-1];
         assign lhit = c_hit[i-1];
      end
      if (i == CAPACITY-1) begin : g_last
         assign rv = 1'b0;
         assign rk = '0;
         assign rh = '0;
      end else begin : g_inner
         assign rv = c_valid[i+1];
         assign rk = c_key[i+1];
         assign rh = c_handle[i+1];
      end
      slpq_cell #(.HW(AW), .CW(CW)) u_cell (
         .clock(clock), .reset(reset), .ctrl(ctrl), .new_handle(new_handle),
         .target(tgt_ff), .left_valid(lv), .left_key(lk), .left_handle(lh),
         .left_ge(lge), .left_hit(lhit), .right_valid(rv), .right_key(rk),
         .right_handle(rh), .valid(c_valid[i]), .key(c_key[i]),
         .handle(c_handle[i]), .ge(c_ge[i]), .hit(c_hit[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
         used_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (accept) begin
                  st_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               st_ff        <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               if (ctrl.clr) begin
                  sp_ff   <= '0;
                  used_ff <= '0;
               end else if (ctrl.ins) begin
                  if (sp_ff != '0) begin
                     sp_ff <= sp_ff - 1'b1;
                  end else begin
                     used_ff <= used_ff + 1'b1;
                  end
               end else if (do_push) begin
                  sp_ff <= sp_ff + 1'b1;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // command word, free-stack top, slot memories and response registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_cmd;
         pos_ff      <= req_position;
         g_ff        <= req_cost_so_far;
         h_ff        <= req_cost_estimate;
         tgt_ff      <= CW'(req_target_handle);
         stack_rd_ff <= stack_mem[sp_ff[AW-1:0] - 1'b1];
      end
      if (do_push) begin
         stack_mem[sp_ff[AW-1:0]] <= push_handle;
      end
      if (ctrl.ins) begin
         mem_pos[new_handle] <= pos_ff;
         mem_g[new_handle]   <= g_ff;
         mem_h[new_handle]   <= h_ff;
         dpos_ff <= pos_ff;
         dg_ff   <= g_ff;
         dh_ff   <= h_ff;
      end else if (ctrl.pop || ctrl.rem) begin
         dpos_ff <= mem_pos[rd_addr];
         dg_ff   <= mem_g[rd_addr];
         dh_ff   <= mem_h[rd_addr];
      end
      if (exec) begin
         case (cmd_ff)
            CMD_INSERT: begin
               status_ff <= full ? STATUS_FULL : STATUS_OK;
               show_ff   <= !full;
               hnd_ff    <= CW'(new_handle);
            end
            CMD_POP: begin
               status_ff <= c_valid[0] ? STATUS_OK : STATUS_EMPTY;
               show_ff   <= c_valid[0];
               hnd_ff    <= CW'(c_handle[0]);
            end
            CMD_REMOVE: begin
               status_ff <= found ? STATUS_OK : STATUS_NOT_FOUND;
               show_ff   <= found;
               hnd_ff    <= tgt_ff;
            end
            default: begin
               status_ff <= STATUS_OK;
               show_ff   <= 1'b0;
               hnd_ff    <= '0;
            end
         endcase
      end
   end

   logic [CW-1:0] head_w;
   assign head_w = c_valid[0] ? CW'(c_handle[0]) : '0;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_node_handle        = show_ff ? hnd_ff[7:0] : 8'd0;
   assign rsp_node_position      = show_ff ? dpos_ff : 16'd0;
   assign rsp_node_cost_so_far   = show_ff ? dg_ff : 16'd0;
   assign rsp_node_cost_estimate = show_ff ? dh_ff : 16'd0;
   assign rsp_node_total         = show_ff ? (17'(dg_ff) + 17'(dh_ff)) : 17'd0;
   assign rsp_head_handle        = head_w[7:0];
   assign rsp_is_empty           = !c_valid[0];

endmodule

[src/slpq_checker.sv]
`include "assert_macros.svh"

module slpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_node_total,
   input logic [7:0]  rsp_head_handle,
   input logic        rsp_is_empty
);
   import slpq_pkg::*;

   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))
   `AST_SAME(a_empty_head, clock, reset, rsp_valid && rsp_is_empty, rsp_head_handle == 8'd0)
   `AST_SAME(a_pop_empty, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), rsp_is_empty)
   `AST_SAME(a_full_busy, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), !rsp_is_empty)
   `AST_SAME(a_fail_zero, clock, reset, rsp_valid && (rsp_status == STATUS_NOT_FOUND), rsp_node_total == 17'd0)

endmodule

bind sorted_list_priority_queue_unit slpq_checker u_slpq_checker (.*);

[tb/tb_sorted_list_priority_queue_unit.sv]
`timescale 1ns / 100ps

module tb_sorted_list_priority_queue_unit;
   import slpq_pkg::*;

   localparam int SLOTS      = 256;
   localparam int NO_SLOT    = SLOTS;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  handle;
      logic [15:0] position;
      logic [15:0] cost_so_far;
      logic [15:0] cost_estimate;
      logic [16:0] total;
      logic [7:0]  head;
      logic        empty;
   } queue_reply_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [15:0] req_position;
   logic [15:0] req_cost_so_far;
   logic [15:0] req_cost_estimate;
   logic [7:0]  req_target_handle;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_node_handle;
   logic [15:0] rsp_node_position;
   logic [15:0] rsp_node_cost_so_far;
   logic [15:0] rsp_node_cost_estimate;
   logic [16:0] rsp_node_total;
   logic [7:0]  rsp_head_handle;
   logic        rsp_is_empty;

   sorted_list_priority_queue_unit dut (.*);

   // shadow of the queue
   logic [15:0] node_pos [SLOTS];
   logic [15:0] node_g [SLOTS];
   logic [15:0] node_h [SLOTS];
   int          node_next [SLOTS];
   int          head_slot, tail_slot, free_slot, slots_taken;

   queue_reply_type pending_replies[$];
   int           fail_count;
   int           cycle_count;
   int           long_hold;
   bit           no_idle;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [16:0] key_at(int s);
      return {1'b0, node_g[s]} + {1'b0, node_h[s]};
   endfunction

   function automatic void fill_node(ref queue_reply_type r, input int s);
      r.handle        = s[7:0];
      r.position      = node_pos[s];
      r.cost_so_far   = node_g[s];
      r.cost_estimate = node_h[s];
      r.total         = key_at(s);
   endfunction

   function automatic queue_reply_type queue_step(logic [1:0] cmd, logic [15:0] pos,
                                                  logic [15:0] g, logic [15:0] h,
                                                  logic [7:0] target);
      queue_reply_type r;
      int           idx, prev, cur;
      logic [16:0]  f;
      r = '{default: '0};
      case (cmd)
         CMD_INSERT: begin
            idx = NO_SLOT;
            if (free_slot != NO_SLOT) begin
               idx = free_slot;
               free_slot = node_next[idx];
            end else if (slots_taken < SLOTS) begin
               idx = slots_taken;
               slots_taken++;
            end
            if (idx == NO_SLOT) begin
               r.status = STATUS_FULL;
            end else begin
               node_pos[idx] = pos;
               node_g[idx] = g;
               node_h[idx] = h;
               f = key_at(idx);
               prev = NO_SLOT;
               cur = head_slot;
               while (cur != NO_SLOT && f > key_at(cur)) begin
                  prev = cur;
                  cur = node_next[cur];
               end
               node_next[idx] = cur;
               if (prev == NO_SLOT) head_slot = idx;
               else node_next[prev] = idx;
               if (cur == NO_SLOT) tail_slot = idx;
               r.status = STATUS_OK;
               fill_node(r, idx);
            end
         end
         CMD_POP: begin
            if (head_slot == NO_SLOT) begin
               r.status = STATUS_EMPTY;
            end else begin
               idx = head_slot;
               fill_node(r, idx);
               head_slot = node_next[idx];
               if (head_slot == NO_SLOT) tail_slot = NO_SLOT;
               node_next[idx] = free_slot;
               free_slot = idx;
            end
         end
         CMD_REMOVE: begin
            prev = NO_SLOT;
            cur = head_slot;
            while (cur != NO_SLOT && cur != int'(target)) begin
               prev = cur;
               cur = node_next[cur];
            end
            if (cur == NO_SLOT) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               fill_node(r, cur);
               if (prev == NO_SLOT) head_slot = node_next[cur];
               else node_next[prev] = node_next[cur];
               if (cur == tail_slot) tail_slot = prev;
               if (head_slot == NO_SLOT) tail_slot = NO_SLOT;
               node_next[cur] = free_slot;
               free_slot = cur;
            end
         end
         default: begin
            head_slot = NO_SLOT;
            tail_slot = NO_SLOT;
            free_slot = NO_SLOT;
            slots_taken = 0;
         end
      endcase
      if (head_slot != NO_SLOT) r.head = head_slot[7:0];
      else r.empty = 1'b1;
      return r;
   endfunction

   function automatic int queued_count();
      int n, cur;
      n = 0;
      cur = head_slot;
      while (cur != NO_SLOT) begin
         n++;
         cur = node_next[cur];
      end
      return n;
   endfunction

   // pick a live handle most of the time, otherwise any handle
   function automatic logic [7:0] pick_target();
      int n, cur;
      n = queued_count();
      if (n == 0 || $urandom_range(99) < 25) return 8'($urandom_range(255));
      cur = head_slot;
      repeat ($urandom_range(n - 1)) cur = node_next[cur];
      return cur[7:0];
   endfunction

   function automatic logic [15:0] pick_cost();
      int r;
      r = $urandom_range(99);
      if (r < 6) return 16'hFFFF;
      if (r < 12) return 16'h0000;
      if (r < 60) return 16'($urandom_range(15));
      return 16'($urandom);
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(logic [1:0] cmd, logic [15:0] pos, logic [15:0] g,
                            logic [15:0] h, logic [7:0] target);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd = cmd;
      req_position = pos;
      req_cost_so_far = g;
      req_cost_estimate = h;
      req_target_handle = target;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(queue_step(cmd, pos, g, h, target));
      @(negedge clock);
   endtask

   task automatic send_random(int weight_insert, int weight_pop, int weight_remove);
      int r;
      r = $urandom_range(weight_insert + weight_pop + weight_remove);
      if (r < weight_insert)
         send_word(CMD_INSERT, 16'($urandom), pick_cost(), pick_cost(), 8'($urandom));
      else if (r < weight_insert + weight_pop)
         send_word(CMD_POP, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      else if (r < weight_insert + weight_pop + weight_remove)
         send_word(CMD_REMOVE, 16'($urandom), 16'($urandom), 16'($urandom), pick_target());
      else
         send_word(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_word(CMD_POP, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_word(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_word(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      // equal keys: newest goes first
      send_word(CMD_INSERT, 16'h1234, 16'd5, 16'd5, 8'h00);
      send_word(CMD_INSERT, 16'h4321, 16'd3, 16'd7, 8'h00);
      send_word(CMD_INSERT, 16'hA5A5, 16'd10, 16'd0, 8'h00);
      send_word(CMD_INSERT, 16'h5A5A, 16'd40, 16'd2, 8'h00);
      // unlink the tail, then the head, then two absent handles
      send_word(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'd0);
      send_word(CMD_INSERT, 16'h0F0F, 16'd50, 16'd50, 8'h00);
      send_word(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'd1);
      send_word(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'd1);
      send_word(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
      repeat (3) send_word(CMD_POP, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(CMD_INSERT, 16'h00FF, 16'hFFFF, 16'h0001, 8'h00);
      send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(CMD_INSERT, 16'hFF00, 16'd1, 16'd1, 8'h00);
      send_word(CMD_POP, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_word(CMD_POP, 16'h0000, 16'h0000, 16'h0000, 8'h00);
   endtask

   task automatic test_full_queue();
      send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      repeat (SLOTS + 2)
         send_word(CMD_INSERT, 16'($urandom), pick_cost(), pick_cost(), 8'h00);
      send_word(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 8'($urandom));
      send_word(CMD_INSERT, 16'($urandom), pick_cost(), pick_cost(), 8'h00);
      send_word(CMD_INSERT, 16'($urandom), pick_cost(), pick_cost(), 8'h00);
      repeat (SLOTS + 1) send_random(0, 1, 0);
   endtask

   task automatic test_back_pressure();
      wait_drained();
      long_hold = 200;
      repeat (30) send_random(5, 3, 2);
      // pause until everything has come back
      wait_drained();
      repeat (3) @(negedge clock);
   endtask

   task automatic test_random_mix();
      for (int blk = 0; blk < 14; blk++) begin
         no_idle = (blk % 5 == 2);
         repeat (75) begin
            case (blk % 4)
               0: send_random(6, 2, 2);
               1: send_random(3, 4, 3);
               2: send_random(8, 1, 1);
               default: send_random(2, 6, 2);
            endcase
         end
      end
      no_idle = 1'b0;
   endtask

   task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t unexpected word: expected none, actual status %0h", $time,
                     rsp_status);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("node_handle", want.handle, rsp_node_handle);
            check_field("node_position", want.position, rsp_node_position);
            check_field("node_cost_so_far", want.cost_so_far, rsp_node_cost_so_far);
            check_field("node_cost_estimate", want.cost_estimate, rsp_node_cost_estimate);
            check_field("node_total", want.total, rsp_node_total);
            check_field("head_handle", want.head, rsp_head_handle);
            check_field("is_empty", want.empty, rsp_is_empty);
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      static int run_left = 0;
      int r;
      if (long_hold > 0) begin
         rsp_stall = 1'b1;
         long_hold--;
      end else if (no_idle) begin
         rsp_stall = 1'b0;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         r = $urandom_range(99);
         if (r < 60) begin
            rsp_stall = 1'b0;
            run_left = $urandom_range(8);
         end else if (r < 95) begin
            rsp_stall = 1'b1;
            run_left = $urandom_range(3);
         end else begin
            rsp_stall = 1'b1;
            run_left = $urandom_range(10, 40);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_INSERT;
      req_position = '0;
      req_cost_so_far = '0;
      req_cost_estimate = '0;
      req_target_handle = '0;
      rsp_stall = 1'b0;
      long_hold = 0;
      no_idle = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      head_slot = NO_SLOT;
      tail_slot = NO_SLOT;
      free_slot = NO_SLOT;
      slots_taken = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_queue();
      test_back_pressure();
      test_random_mix();

      wait_drained();
      repeat (20) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $display("%0t %0d words never arrived: expected 0, actual %0d", $time,
                  pending_replies.size(), pending_replies.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/slpq_pkg.sv
src/slpq_cell.sv
src/sorted_list_priority_queue_unit.sv
src/slpq_checker.sv
tb/tb_sorted_list_priority_queue_unit.sv
